// File: hdl/uer_pkg.sv
package uer_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_WIDTH = 16;
	localparam int DIST_WIDTH = 16;

	localparam logic [CFG_WIDTH-1:0] TRIGGER_TICKS_RST = 16'd30;
	localparam logic [CFG_WIDTH-1:0] TICKS_PER_CM_RST = 16'd116;
	localparam logic [DIST_WIDTH-1:0] DIST_MAX = 16'hFFFF;

	// register index, taken from paddr[2]
	localparam logic REG_TRIGGER_TICKS = 1'b0;
	localparam logic REG_TICKS_PER_CM = 1'b1;

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_BUSY = 2'd1;
	localparam logic [1:0] STATUS_VALID = 2'd2;

	typedef enum logic [2:0] {
		PH_READY = 3'd0,
		PH_TRIGGER = 3'd1,
		PH_WAIT = 3'd2,
		PH_MEASURE = 3'd3,
		PH_AVAIL = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_RUN = 2'd0,
		SEQ_DIV = 2'd1,
		SEQ_FIN = 2'd2
	} seq_t;

	typedef struct packed {
		logic step;
		logic trig_load;
		logic trig_inc;
		logic echo_clr;
		logic echo_inc;
		logic div_start;
		logic held_load;
		logic out_load;
		logic out_pin;
		logic out_acc;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic echo;
		logic start;
		logic echo_rise;
		logic trig_done;
		logic div_busy;
	} sts_t;

endpackage

// File: hdl/uer_regs.sv
module uer_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [uer_pkg::CFG_WIDTH-1:0] trigger_ticks,
	output logic [uer_pkg::CFG_WIDTH-1:0] ticks_per_cm
);
	import uer_pkg::*;

	logic [CFG_WIDTH-1:0] trigger_ticks_q;
	logic [CFG_WIDTH-1:0] ticks_per_cm_q;
	logic wr_en;
	logic reg_idx;

	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= TRIGGER_TICKS_RST;
			ticks_per_cm_q <= TICKS_PER_CM_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TRIGGER_TICKS: trigger_ticks_q <= pwdata[CFG_WIDTH-1:0];
				REG_TICKS_PER_CM: ticks_per_cm_q <= pwdata[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRIGGER_TICKS: prdata = 32'(trigger_ticks_q);
			REG_TICKS_PER_CM: prdata = 32'(ticks_per_cm_q);
			default: prdata = '0;
		endcase
	end

	assign trigger_ticks = trigger_ticks_q;
	assign ticks_per_cm = ticks_per_cm_q;

endmodule

// File: hdl/uer_dp.sv
module uer_dp #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_echo,
	input  logic in_start,
	input  logic [uer_pkg::CFG_WIDTH-1:0] trigger_ticks,
	input  logic [uer_pkg::CFG_WIDTH-1:0] ticks_per_cm,
	input  uer_pkg::cmd_t cmd,
	output uer_pkg::sts_t sts,
	output logic out_pin,
	output logic out_acc,
	output logic [1:0] out_status,
	output logic [uer_pkg::DIST_WIDTH-1:0] out_dist
);
	import uer_pkg::*;

	localparam int CNTW = $clog2(COUNT_WIDTH + 1);
	localparam int QW = (COUNT_WIDTH > DIST_WIDTH) ? COUNT_WIDTH : DIST_WIDTH;

	logic last_echo_q;
	logic [CFG_WIDTH-1:0] trig_cnt_q;
	logic [COUNT_WIDTH-1:0] echo_cnt_q;
	logic [COUNT_WIDTH-1:0] echo_cnt_inc;
	logic [CFG_WIDTH-1:0] trig_len;

	logic [COUNT_WIDTH-1:0] dvd_q;
	logic [CFG_WIDTH-1:0] rem_q;
	logic [CNTW-1:0] div_cnt_q;
	logic [CFG_WIDTH:0] rem_sh;
	logic [CFG_WIDTH:0] rem_nx;
	logic quo_bit;
	logic [QW-1:0] quo_ext;
	logic [DIST_WIDTH-1:0] dist_nx;

	logic [DIST_WIDTH-1:0] held_q;
	logic pin_q;
	logic acc_q;
	logic [1:0] status_q;
	logic [DIST_WIDTH-1:0] dist_q;

	assign trig_len = (trigger_ticks == '0) ? CFG_WIDTH'(1) : trigger_ticks;
	assign echo_cnt_inc = (echo_cnt_q == '1) ? echo_cnt_q : echo_cnt_q + COUNT_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_echo_q <= 1'b0;
		end else if (cmd.step) begin
			last_echo_q <= in_echo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.trig_load) begin
			trig_cnt_q <= CFG_WIDTH'(1);
		end else if (cmd.trig_inc) begin
			trig_cnt_q <= trig_cnt_q + CFG_WIDTH'(1);
		end
		if (cmd.echo_clr) begin
			echo_cnt_q <= '0;
		end else if (cmd.echo_inc) begin
			echo_cnt_q <= echo_cnt_inc;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign rem_sh = {rem_q, dvd_q[COUNT_WIDTH-1]};
	assign quo_bit = rem_sh >= {1'b0, ticks_per_cm};
	assign rem_nx = quo_bit ? rem_sh - {1'b0, ticks_per_cm} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= CNTW'(COUNT_WIDTH);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= echo_cnt_inc;
			rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			dvd_q <= {dvd_q[COUNT_WIDTH-2:0], quo_bit};
			rem_q <= rem_nx[CFG_WIDTH-1:0];
		end
	end

	assign quo_ext = QW'(dvd_q);
	assign dist_nx = (ticks_per_cm == '0 || quo_ext > QW'(DIST_MAX)) ? DIST_MAX
		: quo_ext[DIST_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.held_load) begin
			held_q <= dist_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pin_q <= cmd.out_pin;
			acc_q <= cmd.out_acc;
			status_q <= cmd.out_status;
			dist_q <= (cmd.out_status == STATUS_VALID) ? held_q : '0;
		end
	end

	assign sts.echo = in_echo;
	assign sts.start = in_start;
	assign sts.echo_rise = in_echo && !last_echo_q;
	assign sts.trig_done = trig_cnt_q >= trig_len;
	assign sts.div_busy = div_cnt_q != '0;

	assign out_pin = pin_q;
	assign out_acc = acc_q;
	assign out_status = status_q;
	assign out_dist = dist_q;

endmodule

// File: hdl/uer_ctrl.sv
module uer_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  uer_pkg::sts_t sts,
	output uer_pkg::cmd_t cmd
);
	import uer_pkg::*;

	seq_t seq_q, seq_d;
	phase_t phase_q, phase_d;
	logic out_valid_q;
	logic accept;

	assign in_ready = (seq_q == SEQ_RUN) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_RUN;
			phase_q <= PH_READY;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			phase_q <= phase_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		seq_d = seq_q;
		phase_d = phase_q;
		cmd = '0;
		unique case (seq_q)
			SEQ_RUN: begin
				if (accept) begin
					cmd.step = 1'b1;
					if (sts.start && (phase_q == PH_READY || phase_q == PH_AVAIL)) begin
						cmd.out_acc = 1'b1;
						cmd.out_pin = 1'b1;
						cmd.trig_load = 1'b1;
						phase_d = PH_TRIGGER;
					end else begin
						unique case (phase_q)
							PH_TRIGGER: begin
								if (sts.trig_done) begin
									phase_d = PH_WAIT;
								end else begin
									cmd.out_pin = 1'b1;
									cmd.trig_inc = 1'b1;
								end
							end
							PH_WAIT: begin
								if (sts.echo_rise) begin
									cmd.echo_clr = 1'b1;
									phase_d = PH_MEASURE;
								end
							end
							PH_MEASURE: begin
								cmd.echo_inc = 1'b1;
								if (!sts.echo) begin
									cmd.div_start = 1'b1;
									phase_d = PH_AVAIL;
									seq_d = SEQ_DIV;
								end
							end
							PH_AVAIL: ;
							default: phase_d = PH_READY;
						endcase
					end
					cmd.out_load = (seq_d == SEQ_RUN);
					unique case (phase_d)
						PH_READY: cmd.out_status = STATUS_NONE;
						PH_AVAIL: cmd.out_status = STATUS_VALID;
						default: cmd.out_status = STATUS_BUSY;
					endcase
				end
			end
			SEQ_DIV: begin
				if (!sts.div_busy) begin
					cmd.held_load = 1'b1;
					seq_d = SEQ_FIN;
				end
			end
			SEQ_FIN: begin
				cmd.out_load = 1'b1;
				cmd.out_status = STATUS_VALID;
				seq_d = SEQ_RUN;
			end
			default: seq_d = SEQ_RUN;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger: times the echo pulse of an ultrasonic sensor
// each transfer on the s_axis channel is one timer tick carrying the sampled
// echo level and a start request; each tick yields exactly one transfer on
// m_axis with the trigger pin level, start accepted flag, status and distance
// a start is taken when idle or when a result is shown; the trigger pin is
// then high for trigger_ticks ticks (one tick if it is 0); the echo pulse is counted
// from its rising to its falling edge and the count is divided by ticks_per_cm
// apb registers: 0x0 trigger_ticks, 0x4 ticks_per_cm (16 bit each)
// output: a tick's result is registered and shows in the cycle after its
// transfer; a tick with the falling echo edge starts a restoring divider of
// COUNT_WIDTH quotient bits, and its result is loaded through SEQ_DIV, then SEQ_FIN
// throughput: one tick per cycle unless m_axis stalls, and none during the division
// m_axis has a one-deep output register; a new tick is taken while the
// register is empty or drained in the same cycle, so a stalled receiver holds
// the result stable and stops input after one tick
// reset: idle, no result, held distance 0, registers at 30 and 116
module ultrasonic_echo_ranger #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // echo_level, start_request
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // trigger_pin, start_accepted, status, distance_cm
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import uer_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [CFG_WIDTH-1:0] trigger_ticks;
	logic [CFG_WIDTH-1:0] ticks_per_cm;
	logic out_pin;
	logic out_acc;
	logic [1:0] out_status;
	logic [DIST_WIDTH-1:0] out_dist;

	assign pready = 1'b1;

	uer_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.trigger_ticks(trigger_ticks),
		.ticks_per_cm(ticks_per_cm)
	);

	uer_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts(sts),
		.cmd(cmd)
	);

	uer_dp #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_echo(s_axis_tdata[0]),
		.in_start(s_axis_tdata[1]),
		.trigger_ticks(trigger_ticks),
		.ticks_per_cm(ticks_per_cm),
		.cmd(cmd),
		.sts(sts),
		.out_pin(out_pin),
		.out_acc(out_acc),
		.out_status(out_status),
		.out_dist(out_dist)
	);

	assign m_axis_tdata = {4'b0, out_dist, out_status, out_acc, out_pin};

endmodule

// File: hdl/uer_checker.sv
module uer_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	import uer_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:2] != 2'd3)
		else $error("status code out of range");

	a_start_pin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |->
			m_axis_tdata[0] && m_axis_tdata[3:2] == STATUS_BUSY)
		else $error("accepted start without trigger pulse and pending status");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:2] != STATUS_VALID |-> m_axis_tdata[19:4] == '0)
		else $error("distance shown without a valid result");

endmodule

bind ultrasonic_echo_ranger uer_checker u_chk (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import uer_pkg::*;

	localparam int CW = COUNT_WIDTH_DEF;

	typedef struct packed {
		logic [DIST_WIDTH-1:0] distance_cm;
		logic [1:0] status;
		logic start_accepted;
		logic trigger_pin;
	} tick_result_t;

	typedef struct packed {
		logic echo;
		logic start;
		logic typed;
		tick_result_t res;
	} tick_row_t;

	localparam tick_result_t R_NONE = '0;
	localparam tick_result_t R_IDLE = '{16'd0, STATUS_NONE, 1'b0, 1'b0};
	localparam tick_result_t R_ACCEPT = '{16'd0, STATUS_BUSY, 1'b1, 1'b1};
	localparam tick_result_t R_BUSY = '{16'd0, STATUS_BUSY, 1'b0, 1'b0};
	localparam tick_result_t R_MAXCM = '{DIST_MAX, STATUS_VALID, 1'b0, 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // echo_level, start_request
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;      // trigger_pin, start_accepted, status, distance_cm
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int sent_ticks = 0;

	tick_result_t expected_q[$];
	tick_row_t directed_rows[19];

	phase_t rng_phase;
	logic [CW-1:0] rng_count;
	logic rng_last_echo;
	logic [DIST_WIDTH-1:0] rng_held_cm;
	logic [CFG_WIDTH-1:0] cfg_trig_ticks;
	logic [CFG_WIDTH-1:0] cfg_ticks_per_cm;

	ultrasonic_echo_ranger dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// one timer tick of the ranger
	task automatic advance_ranger(input logic echo, input logic start, output tick_result_t r);
		logic [CFG_WIDTH-1:0] len;
		int quot;
		r = '0;
		if (start && (rng_phase == PH_READY || rng_phase == PH_AVAIL)) begin
			r.start_accepted = 1'b1;
			r.trigger_pin = 1'b1;
			rng_count = CW'(1);
			rng_phase = PH_TRIGGER;
		end else if (rng_phase == PH_TRIGGER) begin
			len = (cfg_trig_ticks == '0) ? CFG_WIDTH'(1) : cfg_trig_ticks;
			if (rng_count >= len) begin
				rng_phase = PH_WAIT;
			end else begin
				r.trigger_pin = 1'b1;
				rng_count = rng_count + 1'b1;
			end
		end else if (rng_phase == PH_WAIT) begin
			if (echo && !rng_last_echo) begin
				rng_count = '0;
				rng_phase = PH_MEASURE;
			end
		end else if (rng_phase == PH_MEASURE) begin
			if (rng_count != '1)
				rng_count = rng_count + 1'b1;
			if (!echo) begin
				if (cfg_ticks_per_cm == '0) begin
					rng_held_cm = DIST_MAX;
				end else begin
					quot = int'(rng_count / cfg_ticks_per_cm);
					rng_held_cm = (quot > int'(DIST_MAX)) ? DIST_MAX : quot[DIST_WIDTH-1:0];
				end
				rng_phase = PH_AVAIL;
			end
		end
		rng_last_echo = echo;
		case (rng_phase)
			PH_READY: r.status = STATUS_NONE;
			PH_AVAIL: begin
				r.status = STATUS_VALID;
				r.distance_cm = rng_held_cm;
			end
			default: r.status = STATUS_BUSY;
		endcase
	endtask

	task automatic send_tick(input logic echo, input logic start, input logic typed,
			input tick_result_t typed_res);
		tick_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, start, echo};
		do @(posedge clk); while (!s_axis_tready);
		advance_ranger(echo, start, r);
		expected_q.push_back(typed ? typed_res : r);
		sent_ticks++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_access(input logic idx, input logic wr, input logic [CFG_WIDTH-1:0] val);
		logic [15:0] junk;
		junk = 16'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {junk, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			if (idx == REG_TRIGGER_TICKS)
				cfg_trig_ticks = val;
			else
				cfg_ticks_per_cm = val;
		end else begin
			check_field("prdata",
				int'((idx == REG_TRIGGER_TICKS) ? cfg_trig_ticks : cfg_ticks_per_cm),
				int'(prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_range(input logic [CFG_WIDTH-1:0] trig, input logic [CFG_WIDTH-1:0] per_cm);
		reg_access(REG_TRIGGER_TICKS, 1'b1, trig);
		reg_access(REG_TICKS_PER_CM, 1'b1, per_cm);
		reg_access(REG_TRIGGER_TICKS, 1'b0, '0);
		reg_access(REG_TICKS_PER_CM, 1'b0, '0);
	endtask

	// start, wait out trigger, echo pulse, a few quiet ticks
	task automatic run_measurement(input int wait_ticks, input int pulse_ticks, input bit noisy);
		send_tick(noisy && ($urandom_range(1) == 1), 1'b1, 1'b0, R_NONE);
		repeat (wait_ticks)
			send_tick(noisy && ($urandom_range(7) == 0), noisy && ($urandom_range(7) == 0),
				1'b0, R_NONE);
		repeat (pulse_ticks)
			send_tick(1'b1, noisy && ($urandom_range(15) == 0), 1'b0, R_NONE);
		repeat ($urandom_range(1, 4))
			send_tick(1'b0, noisy && ($urandom_range(7) == 0), 1'b0, R_NONE);
	endtask

	always @(posedge clk) begin : result_monitor
		tick_result_t got;
		tick_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[19:0];
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: transfer with nothing expected, actual %h", $time, m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				check_field("trigger_pin", int'(want.trigger_pin), int'(got.trigger_pin));
				check_field("start_accepted", int'(want.start_accepted),
					int'(got.start_accepted));
				check_field("status", int'(want.status), int'(got.status));
				check_field("distance_cm", int'(want.distance_cm), int'(got.distance_cm));
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin : stimulus
		int trig_set[9];
		int cm_set[9];
		int pulse;
		rng_phase = PH_READY;
		rng_count = '0;
		rng_last_echo = 1'b0;
		rng_held_cm = '0;
		cfg_trig_ticks = TRIGGER_TICKS_RST;
		cfg_ticks_per_cm = TICKS_PER_CM_RST;

		// trigger length zero and divisor zero throughout this table
		directed_rows = '{
			'{1'b0, 1'b0, 1'b1, R_IDLE},
			'{1'b1, 1'b0, 1'b1, R_IDLE},
			'{1'b0, 1'b1, 1'b1, R_ACCEPT},
			'{1'b0, 1'b1, 1'b1, R_BUSY},
			'{1'b1, 1'b0, 1'b0, R_NONE},
			'{1'b1, 1'b0, 1'b0, R_NONE},
			'{1'b0, 1'b0, 1'b1, R_MAXCM},
			'{1'b0, 1'b0, 1'b1, R_MAXCM},
			'{1'b1, 1'b1, 1'b1, R_ACCEPT},
			'{1'b1, 1'b0, 1'b0, R_NONE},
			'{1'b1, 1'b0, 1'b0, R_NONE},
			'{1'b0, 1'b0, 1'b0, R_NONE},
			'{1'b1, 1'b0, 1'b0, R_NONE},
			'{1'b1, 1'b0, 1'b0, R_NONE},
			'{1'b0, 1'b0, 1'b1, R_MAXCM},
			'{1'b0, 1'b1, 1'b1, R_ACCEPT},
			'{1'b0, 1'b0, 1'b0, R_NONE},
			'{1'b1, 1'b1, 1'b0, R_NONE},
			'{1'b0, 1'b0, 1'b1, R_MAXCM}
		};

		trig_set = '{1, 3, 2, TRIGGER_TICKS_RST, 0, 1, 0, 0, 0};
		cm_set = '{1, 5, 65535, TICKS_PER_CM_RST, 7, 0, 0, 0, 0};
		for (int i = 6; i < 9; i++) begin
			trig_set[i] = $urandom_range(1, 12);
			cm_set[i] = $urandom_range(1, 40);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_access(REG_TRIGGER_TICKS, 1'b0, '0);
		reg_access(REG_TICKS_PER_CM, 1'b0, '0);

		send_idle_pct = 13;
		recv_idle_pct = 66;
		set_range('0, '0);
		foreach (directed_rows[i])
			send_tick(directed_rows[i].echo, directed_rows[i].start, directed_rows[i].typed,
				directed_rows[i].res);
		drain();

		for (int p = 0; p < 9; p++) begin
			if (p < 3) begin
				send_idle_pct = 13;
				recv_idle_pct = 66;
			end else if (p < 6) begin
				send_idle_pct = 66;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_range(CFG_WIDTH'(trig_set[p]), CFG_WIDTH'(cm_set[p]));
			sent_ticks = 0;
			while (sent_ticks < 120) begin
				if ($urandom_range(4) == 0) begin
					repeat ($urandom_range(1, 8))
						send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, R_NONE);
				end else begin
					pulse = ($urandom_range(9) == 0) ? $urandom_range(61, 400)
						: $urandom_range(1, 60);
					run_measurement(trig_set[p] + $urandom_range(0, 4), pulse, 1'b1);
				end
			end
			drain();
		end

		repeat (CW + 8) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/uer_pkg.sv
hdl/uer_regs.sv
hdl/uer_dp.sv
hdl/uer_ctrl.sv
hdl/ultrasonic_echo_ranger.sv
hdl/uer_checker.sv
test/tb_top.sv
